### hdl/sdr_pkg.sv
// shared types and constants for the stream duplicate remover
`timescale 1ns / 1ps

package sdr_pkg;

    // default size of the seen-value set
    localparam int MAX_DISTINCT_DEF = 64;

    // width of one list element
    localparam int VALUE_W = 32;

    // bit positions inside the result tuser
    localparam int TUSER_KEEP     = 0;
    localparam int TUSER_OVERFLOW = 1;
    localparam int TUSER_W        = 2;

    // request travelling down the cell chain
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      hit;     // matched a stored entry upstream
        logic                      stored;  // already written into some cell
    } sdr_token_t;

endpackage

### hdl/sdr_cell.sv
// one cell of the seen-value chain: holds one entry and passes requests on
`timescale 1ns / 1ps

module sdr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  sdr_pkg::sdr_token_t tok_in,
    output sdr_pkg::sdr_token_t tok_out,
    output logic               occupied
);

    sdr_pkg::sdr_token_t              tok_reg;
    sdr_pkg::sdr_token_t              tok_next;
    logic                             occ_reg;
    logic                             occ_next;
    logic signed [sdr_pkg::VALUE_W-1:0] entry_reg;
    logic signed [sdr_pkg::VALUE_W-1:0] entry_next;
    logic                             match;
    logic                             take;

    // compare against the held entry, claim the cell if it is the first free one
    always_comb
    begin
        match      = occ_reg && (entry_reg == tok_in.value);
        take       = tok_in.valid && !tok_in.hit && !tok_in.stored && !occ_reg;
        tok_next   = tok_in;
        tok_next.hit    = tok_in.hit | match;
        tok_next.stored = tok_in.stored | take;
        occ_next   = occ_reg;
        entry_next = entry_reg;
        if (adv && tok_in.valid)
        begin
            if (take)
            begin
                occ_next   = 1'b1;
                entry_next = tok_in.value;
            end
            // end of list empties the set behind this request
            if (tok_in.last)
            begin
                occ_next = 1'b0;
            end
        end
    end

    // control state and forwarded request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            occ_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                tok_reg <= tok_next;
            end
            occ_reg <= occ_next;
        end
    end

    // stored entry, meaningful only while occupied
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out  = tok_reg;
    assign occupied = occ_reg;

endmodule

### hdl/stream_duplicate_remover_unit.sv
// top level of the stream duplicate remover: a chain of seen-value cells
// Usage:
//   s_axis carries list elements: tdata holds the signed value, tlast marks
//   the final element of a list. m_axis carries one result per request:
//   tdata holds the value passed through, tlast copies the marker, tuser
//   holds keep (first occurrence) and overflow (set full, value not stored).
//   Each request walks one cell per cycle, unless the receiver stalls, down
//   a row of MAX_DISTINCT cells; every cell compares its entry and the first
//   free cell stores a new value. m_axis_tvalid rises once the request has
//   passed the registers of all MAX_DISTINCT cells. Throughput is one
//   request per cycle unless the receiver stalls, set by the one-cell step
//   of the chain; requests follow each other back to back through the cells.
//   A tlast request empties each cell as it passes, so the next list starts
//   with an empty set.
//   Reset empties every cell and the chain; no clearing pass is needed.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and s_axis_tready falls until the result is taken.
`timescale 1ns / 1ps

module stream_duplicate_remover_unit #(
    parameter int MAX_DISTINCT = sdr_pkg::MAX_DISTINCT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sdr_pkg::VALUE_W-1:0]   s_axis_tdata,   // value
    input  logic                          s_axis_tlast,   // last
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sdr_pkg::VALUE_W-1:0]   m_axis_tdata,   // out_value
    output logic                          m_axis_tlast,   // out_last
    output logic [sdr_pkg::TUSER_W-1:0]   m_axis_tuser    // keep, overflow
);

    sdr_pkg::sdr_token_t     chain [0:MAX_DISTINCT];
    logic [MAX_DISTINCT-1:0] occ;
    logic                    adv;

    // chain moves whenever the output slot is free or being emptied
    assign adv           = !chain[MAX_DISTINCT].valid || m_axis_tready;
    assign s_axis_tready = adv;

    // incoming request enters the first cell
    always_comb
    begin
        chain[0]        = '0;
        chain[0].valid  = s_axis_tvalid;
        chain[0].value  = s_axis_tdata;
        chain[0].last   = s_axis_tlast;
        chain[0].hit    = 1'b0;
        chain[0].stored = 1'b0;
    end

    // row of cells
    for (genvar i = 0; i < MAX_DISTINCT; i++)
    begin : g_cell
        sdr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1]),
            .occupied (occ[i])
        );
    end

    // result from the end of the chain
    assign m_axis_tvalid = chain[MAX_DISTINCT].valid;
    assign m_axis_tdata  = chain[MAX_DISTINCT].value;
    assign m_axis_tlast  = chain[MAX_DISTINCT].last;
    always_comb
    begin
        m_axis_tuser = '0;
        m_axis_tuser[sdr_pkg::TUSER_KEEP]     = !chain[MAX_DISTINCT].hit;
        m_axis_tuser[sdr_pkg::TUSER_OVERFLOW] = !chain[MAX_DISTINCT].hit &&
                                                !chain[MAX_DISTINCT].stored;
    end

    // overflow only ever comes with a kept value
    a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[sdr_pkg::TUSER_OVERFLOW]
        |-> m_axis_tuser[sdr_pkg::TUSER_KEEP])
        else $error("overflow flagged on a dropped value");

    // a waiting result holds steady until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a request that does not end its list leaves the first cell occupied
    a_head_taken: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s_axis_tvalid && !s_axis_tlast |=> occ[0])
        else $error("first cell empty after a mid-list request");

endmodule
